[hw/rtl/hcbp_pkg.sv]
// ----------------------------------------------------------------------------
// hcbp_pkg: shared types and constants of the Huffman code bit packer
// Field widths, action codes, code table entry and result byte layout.
// ----------------------------------------------------------------------------
package hcbp_pkg;

	// Table geometry and code limits
	localparam int SYMBOL_COUNT = 256;
	localparam int MAX_CODE_LEN = 16;
	localparam int SYM_W        = 8;
	localparam int SYM_IDX_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int CODE_W       = 16;
	localparam int LEN_W        = 5;
	localparam int CODE_CAP     = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

	// Bit packer widths
	localparam int BYTE_W   = 8;
	localparam int NBITS_W  = 4;
	localparam int PEND_W   = BYTE_W - 1;
	localparam int PCNT_W   = 3;
	localparam int ACC_W    = PEND_W + CODE_W;
	localparam int TOTAL_W  = 5;

	// Result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FPTR_W     = 2;
	localparam int FCNT_W     = 3;

	// Action codes
	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_ENCODE = 2'd1,
		ACT_FLUSH  = 2'd2
	} action_t;

	// One code table entry
	typedef struct packed {
		logic [CODE_W-1:0] word;
		logic [LEN_W-1:0]  len;
	} entry_t;

	// One result byte
	typedef struct packed {
		logic [BYTE_W-1:0]  out_byte;
		logic [NBITS_W-1:0] valid_bits;
		logic               last_of_run;
	} result_t;

endpackage

[hw/rtl/hcbp_stream_if.sv]
// ----------------------------------------------------------------------------
// hcbp_stream_if: valid/ready channels of the Huffman code bit packer
// Input item channel and result byte channel, each with source and sink.
// ----------------------------------------------------------------------------
interface hcbp_item_if
	import hcbp_pkg::*;
	();

	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [SYM_W-1:0]  symbol;
	logic [CODE_W-1:0] code_word;
	logic [LEN_W-1:0]  code_length;

	modport source (output valid, action, symbol, code_word, code_length, input ready);
	modport sink   (input valid, action, symbol, code_word, code_length, output ready);

endinterface

interface hcbp_result_if
	import hcbp_pkg::*;
	();

	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  out_byte;
	logic [NBITS_W-1:0] valid_bits;
	logic               last_of_run;

	modport source (output valid, out_byte, valid_bits, last_of_run, input ready);
	modport sink   (input valid, out_byte, valid_bits, last_of_run, output ready);

endinterface

[hw/rtl/huffman_code_bit_packer_unit.sv]
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit: table-driven Huffman encoder and byte packer
// Loads a code table, packs code words MSB first and emits whole bytes, a partial one on flush.
// ----------------------------------------------------------------------------
// On an item transfer on the item channel, a load writes the code table
// memory, an encode reads it and a flush needs no read. In the next cycle the
// packer merges the code with the pending bits and pushes zero, one or two
// result bytes into a four-entry result queue; the last byte of each item
// carries last_of_run. A new item is taken every cycle while the queue has
// room for two more bytes beyond what is already queued or in flight, so the
// sustained rate is set by the result channel at one byte per cycle.
// The table is cleared at reset by one valid flag per entry, so no clearing
// pass is needed and the block is ready right after reset.
module huffman_code_bit_packer_unit
	import hcbp_pkg::*;
	(
	input  logic              clk,
	input  logic              arst_n,
	hcbp_item_if.sink         item,
	hcbp_result_if.source     result
);

	// Code table memory and per-entry valid flags
	entry_t               table_mem [SYMBOL_COUNT];
	logic                 vld_q [SYMBOL_COUNT];

	// Stage 1
	logic                 busy_s1;
	action_t              op_s1;
	entry_t               entry_s1;
	logic                 hit_s1;

	// Packer state
	logic [PEND_W-1:0]    pend_q;
	logic [PCNT_W-1:0]    pcnt_q;

	// Result queue
	result_t              fifo_q [FIFO_DEPTH];
	logic [FPTR_W-1:0]    wptr_q;
	logic [FPTR_W-1:0]    rptr_q;
	logic [FCNT_W-1:0]    fcnt_q;

	action_t              act;
	logic                 take;
	logic                 pop;
	logic                 in_range;
	logic [SYM_IDX_W-1:0] idx;
	entry_t               wr_entry;
	logic [LEN_W-1:0]     cap_len;

	logic [LEN_W-1:0]     len_e;
	logic [CODE_W-1:0]    code_e;
	logic [ACC_W-1:0]     acc;
	logic [TOTAL_W-1:0]   total;
	logic [TOTAL_W-1:0]   total_d;
	logic [BYTE_W-1:0]    byte_hi;
	logic [BYTE_W-1:0]    byte_lo;
	logic [BYTE_W-1:0]    byte_fl;
	logic [PEND_W-1:0]    pend_d;
	logic [PCNT_W-1:0]    pcnt_d;
	logic                 upd_pend;
	logic [1:0]           push_n;
	result_t              push0;
	result_t              push1;
	logic [FCNT_W:0]      room_need;

	// Decode the incoming item
	assign act      = action_t'(item.action);
	assign in_range = ({1'b0, item.symbol} < (SYM_W+1)'(SYMBOL_COUNT));
	assign idx      = item.symbol[SYM_IDX_W-1:0];
	assign take     = item.valid && item.ready;
	assign pop      = result.valid && result.ready;

	// Saturate long codes on load
	assign cap_len       = (item.code_length > LEN_W'(CODE_CAP)) ? LEN_W'(CODE_CAP)
	                                                             : item.code_length;
	assign wr_entry.word = item.code_word;
	assign wr_entry.len  = cap_len;

	// Hold off items unless two queue slots stay free after the in-flight item
	assign room_need  = (FCNT_W+1)'(fcnt_q) + (busy_s1 ? (FCNT_W+1)'(2) : '0)
	                  - (pop ? (FCNT_W+1)'(1) : '0);
	assign item.ready = (room_need <= (FCNT_W+1)'(FIFO_DEPTH - 2));

	// Write on load, read on encode
	always_ff @(posedge clk) begin
		if (take && in_range && act == ACT_LOAD) begin
			table_mem[idx] <= wr_entry;
		end
		if (take && act == ACT_ENCODE) begin
			entry_s1 <= table_mem[idx];
		end
	end

	// Track which entries were ever loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SYMBOL_COUNT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (take && in_range && act == ACT_LOAD) begin
			vld_q[idx] <= 1'b1;
		end
	end

	// Advance encode and flush items into stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			op_s1   <= ACT_LOAD;
			hit_s1  <= 1'b0;
		end else begin
			busy_s1 <= take && ((act == ACT_ENCODE && in_range) || act == ACT_FLUSH);
			op_s1   <= act;
			hit_s1  <= vld_q[idx];
		end
	end

	// Merge the code with the pending bits
	always_comb begin
		len_e   = hit_s1 ? entry_s1.len : '0;
		code_e  = entry_s1.word & CODE_W'((32'd1 << len_e) - 32'd1);
		acc     = (ACC_W'(pend_q) << len_e) | ACC_W'(code_e);
		total   = TOTAL_W'(pcnt_q) + TOTAL_W'(len_e);
		byte_hi = BYTE_W'(acc >> (total - TOTAL_W'(BYTE_W)));
		byte_lo = BYTE_W'(acc >> (total - TOTAL_W'(2 * BYTE_W)));
		byte_fl = BYTE_W'({1'b0, pend_q} << (PCNT_W'(PEND_W) - pcnt_q + PCNT_W'(1)));

		if (total >= TOTAL_W'(2 * BYTE_W)) begin
			total_d = total - TOTAL_W'(2 * BYTE_W);
		end else if (total >= TOTAL_W'(BYTE_W)) begin
			total_d = total - TOTAL_W'(BYTE_W);
		end else begin
			total_d = total;
		end
		pcnt_d = PCNT_W'(total_d);
		pend_d = PEND_W'(acc) & PEND_W'((8'd1 << pcnt_d) - 8'd1);

		push_n   = 2'd0;
		upd_pend = 1'b0;
		push0    = '{out_byte: byte_hi, valid_bits: NBITS_W'(BYTE_W), last_of_run: 1'b1};
		push1    = '{out_byte: byte_lo, valid_bits: NBITS_W'(BYTE_W), last_of_run: 1'b1};

		if (busy_s1) begin
			unique case (op_s1)
				ACT_ENCODE: begin
					if (len_e != '0) begin
						upd_pend = 1'b1;
						if (total >= TOTAL_W'(2 * BYTE_W)) begin
							push_n            = 2'd2;
							push0.last_of_run = 1'b0;
						end else if (total >= TOTAL_W'(BYTE_W)) begin
							push_n = 2'd1;
						end
					end
				end
				ACT_FLUSH: begin
					if (pcnt_q != '0) begin
						push_n   = 2'd1;
						upd_pend = 1'b1;
						pend_d   = '0;
						pcnt_d   = '0;
						push0    = '{out_byte: byte_fl, valid_bits: NBITS_W'(pcnt_q),
						             last_of_run: 1'b1};
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Update the pending bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pcnt_q <= '0;
		end else if (upd_pend) begin
			pend_q <= pend_d;
			pcnt_q <= pcnt_d;
		end
	end

	// Push result bytes into the queue
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wptr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			fifo_q[wptr_q + FPTR_W'(1)] <= push1;
		end
	end

	// Move queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fcnt_q <= '0;
		end else begin
			wptr_q <= wptr_q + FPTR_W'(push_n);
			rptr_q <= rptr_q + FPTR_W'(pop);
			fcnt_q <= fcnt_q + FCNT_W'(push_n) - FCNT_W'(pop);
		end
	end

	// Drive the result channel from the queue head
	assign result.valid       = (fcnt_q != '0);
	assign result.out_byte    = fifo_q[rptr_q].out_byte;
	assign result.valid_bits  = fifo_q[rptr_q].valid_bits;
	assign result.last_of_run = fifo_q[rptr_q].last_of_run;

`ifndef SYNTHESIS
	// The queue never takes more bytes than it has room for
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(FCNT_W+1)'(fcnt_q) + (FCNT_W+1)'(push_n) - (FCNT_W+1)'(pop)
			<= (FCNT_W+1)'(FIFO_DEPTH))
		else $error("result queue overflow");

	// A full queue holds off new items
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(fcnt_q == FCNT_W'(FIFO_DEPTH)) |-> !item.ready)
		else $error("item taken while result queue full");

	// A flush leaves nothing pending
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_s1 && op_s1 == ACT_FLUSH) |=> (pcnt_q == '0))
		else $error("pending bits left after flush");

	// A load never reaches the packer stage
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(take && act == ACT_LOAD) |=> !busy_s1)
		else $error("load item entered packer stage");
`endif

endmodule
